// ===== rtl/core/key_matrix_event_scanner_unit_defines.svh =====
// Assertion macros shared by the key matrix event scanner.
// Both macros sample on clk and are disabled while rst is high.
`ifndef KEY_MATRIX_EVENT_SCANNER_UNIT_DEFINES_SVH
`define KEY_MATRIX_EVENT_SCANNER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KMES_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("kmes: invariant violated");
`define KMES_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmes: implication violated");
`else
`define KMES_ASSERT(lbl, expr)
`define KMES_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/kmes_pkg.sv =====
package kmes_pkg;

  // Matrix geometry
  localparam int DRIVE_LINES  = 6;
  localparam int SENSE_LINES  = 9;
  localparam int NUM_KEYS     = DRIVE_LINES * SENSE_LINES;

  // Field widths
  localparam int DRIVE_W      = 3;
  localparam int SENSE_BITS_W = 9;
  localparam int SENSE_IDX_W  = 4;
  localparam int KEY_W        = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 6;

  // Front-to-back queue
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_KEY = 1'b1;

  localparam logic [KEY_W-1:0] SHIFT_KEY_RESET = 6'd0;
  localparam logic [KEY_W-1:0] ALPHA_KEY_RESET = 6'd9;

  // Sticky modifier mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SHIFT  = 2'd1,
    MODE_ALPHA  = 2'd2
  } mode_t;

  // Per-key record: released, or pressed-in-mode (mode + 1)
  typedef logic [1:0] rec_t;
  localparam rec_t REC_RELEASED = 2'd0;

  typedef rec_t [SENSE_LINES-1:0] row_t;

  // One in-range scan sample, as queued between front and back
  typedef struct packed {
    logic [DRIVE_W-1:0]     drive;
    logic [SENSE_LINES-1:0] bits;
  } item_t;

endpackage

// ===== rtl/core/kmes_front.sv =====
`include "key_matrix_event_scanner_unit_defines.svh"

module kmes_front import kmes_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // scan sample input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DRIVE_W-1:0]      drive_line,
  input  logic [SENSE_BITS_W-1:0] sense_bits,
  // queue head toward the back end
  output logic                    head_valid,
  output item_t                   head,
  input  logic                    pop
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  item_t             item_in;

  // Accept whenever there is room; out-of-range drive lines are dropped here
  assign in_ready   = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready &&
                      ({1'b0, drive_line} < (DRIVE_W + 1)'(DRIVE_LINES));
  assign item_in    = '{drive: drive_line, bits: sense_bits[SENSE_LINES-1:0]};
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `KMES_ASSERT_IMPLY(a_empty_ptrs, count == '0, wr_ptr == rd_ptr)
  `KMES_ASSERT_IMPLY(a_pop_nonempty, pop, count != '0)

endmodule

// ===== rtl/core/kmes_back.sv =====
`include "key_matrix_event_scanner_unit_defines.svh"

module kmes_back import kmes_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // queue head from the front end
  input  logic                   head_valid,
  input  item_t                  head,
  output logic                   pop,
  // event output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_press,
  output logic [DRIVE_W-1:0]     key_drive,
  output logic [SENSE_IDX_W-1:0] key_sense,
  output logic                   shift_flag,
  output logic                   alpha_flag,
  output logic                   last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } seq_state_t;

  seq_state_t             state;
  logic [KEY_W-1:0]       shift_key;
  logic [KEY_W-1:0]       alpha_key;
  row_t                   rows [DRIVE_LINES];
  mode_t                  mode;
  logic [DRIVE_W-1:0]     drive;
  logic [KEY_W-1:0]       key_base;
  logic [SENSE_IDX_W-1:0] sense_idx;
  logic [SENSE_LINES-1:0] pending;
  row_t                   row_cur;

  row_t                   head_row;
  logic [SENSE_LINES-1:0] change;
  rec_t                   rec;
  logic [KEY_W-1:0]       pos;
  logic                   hit;
  logic                   stall;
  logic                   step;
  logic                   emit;
  logic                   press;
  logic [SENSE_LINES-1:0] pending_next;
  row_t                   row_upd;
  mode_t                  mode_next;
  mode_t                  ev_mode;
  logic                   done;

  // Key closure changes for the row at the queue head
  assign head_row = rows[head.drive];
  always_comb begin
    for (int s = 0; s < SENSE_LINES; s++) begin
      change[s] = (head_row[s] != REC_RELEASED) != head.bits[s];
    end
  end

  assign pop = (state == ST_IDLE) && head_valid;

  // One sense line per cycle unless a changed key waits on a stalled output register; only changed keys need it
  assign rec          = row_cur[sense_idx];
  assign pos          = key_base + KEY_W'(sense_idx);
  assign hit          = pending[sense_idx];
  assign stall        = hit && out_valid && !out_ready;
  assign step         = (state == ST_SCAN) && !stall;
  assign emit         = step && hit;
  assign press        = (rec == REC_RELEASED);
  assign pending_next = pending & ~(SENSE_LINES'(1) << sense_idx);
  assign done         = emit && (pending_next == '0);
  assign ev_mode      = press ? mode : mode_t'(rec - rec_t'(1));

  // Record update and next sticky mode
  always_comb begin
    row_upd   = row_cur;
    mode_next = mode;
    if (press) begin
      row_upd[sense_idx] = rec_t'(mode) + rec_t'(1);
      if (pos == shift_key) begin
        mode_next = MODE_SHIFT;
      end else if (pos == alpha_key) begin
        mode_next = MODE_ALPHA;
      end else begin
        mode_next = MODE_NORMAL;
      end
    end else begin
      row_upd[sense_idx] = REC_RELEASED;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_key <= SHIFT_KEY_RESET;
      alpha_key <= ALPHA_KEY_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SHIFT_KEY: shift_key <= cfg_data;
        CFG_ALPHA_KEY: alpha_key <= cfg_data;
        default:       shift_key <= shift_key;
      endcase
    end
  end

  // Sequencer, key records and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mode    <= MODE_NORMAL;
      pending <= '0;
      for (int d = 0; d < DRIVE_LINES; d++) begin
        rows[d] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop && (change != '0)) begin
            state   <= ST_SCAN;
            pending <= change;
          end
        end
        ST_SCAN: begin
          if (emit) begin
            pending <= pending_next;
            mode    <= mode_next;
          end
          if (done) begin
            rows[drive] <= row_upd;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scan context, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      drive     <= head.drive;
      key_base  <= KEY_W'(int'(head.drive) * SENSE_LINES);
      sense_idx <= '0;
      row_cur   <= head_row;
    end else if (step) begin
      sense_idx <= sense_idx + SENSE_IDX_W'(1);
      if (hit) begin
        row_cur <= row_upd;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_press   <= press;
      key_drive  <= drive;
      key_sense  <= sense_idx;
      shift_flag <= (ev_mode == MODE_SHIFT);
      alpha_flag <= (ev_mode == MODE_ALPHA);
      last       <= (pending_next == '0);
    end
  end

  `KMES_ASSERT(a_scan_pending, (state == ST_SCAN) == (pending != '0))
  `KMES_ASSERT_IMPLY(a_sense_range, state == ST_SCAN, sense_idx < SENSE_IDX_W'(SENSE_LINES))
  `KMES_ASSERT_IMPLY(a_done_below, state == ST_SCAN, (pending & ~({SENSE_LINES{1'b1}} << sense_idx)) == '0)

endmodule

// ===== rtl/core/key_matrix_event_scanner_unit.sv =====
// Key matrix event scanner for a 6 by 9 key matrix.
// Input channel (in_valid/in_ready): one transfer per scanned drive line,
// carrying drive_line and its sampled sense_bits. Samples with a drive line
// outside the matrix are accepted and dropped.
// Output channel (out_valid/out_ready): one transfer per key whose state
// changed, in ascending sense order; last marks the final event of a sample.
// A sample with no change produces no transfer.
// Configuration: cfg_wr_en writes cfg_data into the register at cfg_index
// (0 shift key position, 1 alpha key position) in the same cycle.
// A two-entry queue sits between the input side and the scan sequencer.
// An event passes through the queue, the sequencer's load of its sample,
// a scan step for each sense line up to its key, and the output register.
// The sequencer steps through the sense lines up to the last changed key
// and takes the next sample from the queue only once it is back in idle.
// Reset (rst, synchronous): all keys released, mode normal, shift key 0,
// alpha key 9, queue and output register empty.
// A stalled receiver holds the current event; the sequencer waits on the next
// changed key and the queue absorbs up to two further samples.
module key_matrix_event_scanner_unit import kmes_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DRIVE_W-1:0]      drive_line,
  input  logic [SENSE_BITS_W-1:0] sense_bits,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    is_press,
  output logic [DRIVE_W-1:0]      key_drive,
  output logic [SENSE_IDX_W-1:0]  key_sense,
  output logic                    shift_flag,
  output logic                    alpha_flag,
  output logic                    last
);

  logic  head_valid;
  item_t head;
  logic  pop;

  // Accept, range check and queue
  kmes_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .drive_line (drive_line),
    .sense_bits (sense_bits),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Per-key scan, records, mode and event output
  kmes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_press   (is_press),
    .key_drive  (key_drive),
    .key_sense  (key_sense),
    .shift_flag (shift_flag),
    .alpha_flag (alpha_flag),
    .last       (last)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import kmes_pkg::*;

  // Cycles to let the scan queue and sequencer empty out when a sample
  // may still be in flight without producing any event.
  localparam int DRAIN_CYCLES = 40;
  // Long receiver hold-off used to fill the input queue
  localparam int HOLD_CYCLES  = 150;
  // Cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT  = 3000;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic                   is_press;
    logic [DRIVE_W-1:0]     drive;
    logic [SENSE_IDX_W-1:0] sense;
    logic                   shift;
    logic                   alpha;
    logic                   last;
  } key_event_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [DRIVE_W-1:0]      drive_line = '0;
  logic [SENSE_BITS_W-1:0] sense_bits = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    is_press;
  logic [DRIVE_W-1:0]      key_drive;
  logic [SENSE_IDX_W-1:0]  key_sense;
  logic                    shift_flag;
  logic                    alpha_flag;
  logic                    last;

  // Shadow copy of the scanner state
  rec_t             key_state [NUM_KEYS];
  mode_t            cur_mode;
  logic [KEY_W-1:0] shift_pos;
  logic [KEY_W-1:0] alpha_pos;

  key_event_t pending_events [$];

  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int err_count = 0;
  int scans_sent = 0;
  int scans_ignored = 0;
  int events_checked = 0;
  int presses = 0;
  int releases = 0;
  int shift_events = 0;
  int alpha_events = 0;
  int cfg_writes = 0;

  key_matrix_event_scanner_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .drive_line (drive_line),
    .sense_bits (sense_bits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_press   (is_press),
    .key_drive  (key_drive),
    .key_sense  (key_sense),
    .shift_flag (shift_flag),
    .alpha_flag (alpha_flag),
    .last       (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Event predictor
  // ---------------------------------------------------------------------

  function automatic void clear_key_state();
    for (int k = 0; k < NUM_KEYS; k++) key_state[k] = REC_RELEASED;
    cur_mode  = MODE_NORMAL;
    shift_pos = SHIFT_KEY_RESET;
    alpha_pos = ALPHA_KEY_RESET;
  endfunction

  // Append one expected event at the tail of the predictor queue
  function automatic void add_expected(key_event_t ev);
    pending_events = {pending_events, ev};
  endfunction

  // Walk the sense lines of one accepted sample in ascending order and
  // queue one event per key that changed; the final one carries last.
  function automatic void track_scan(logic [DRIVE_W-1:0] drv,
                                     logic [SENSE_BITS_W-1:0] bits);
    key_event_t ev;
    key_event_t held;
    bit         have_held;
    int         pos;
    int         s;
    rec_t       rec;
    mode_t      ev_mode;
    have_held = 1'b0;
    held = '0;
    if (int'(drv) >= DRIVE_LINES) begin
      scans_ignored++;
      return;
    end
    for (s = 0; s < SENSE_LINES; s++) begin
      pos = int'(drv) * SENSE_LINES + s;
      rec = key_state[pos];
      if (rec == REC_RELEASED && bits[s]) begin
        ev_mode = cur_mode;
        key_state[pos] = rec_t'(cur_mode + 2'd1);
        // sticky mode: shift match wins over alpha match
        if (pos == int'(shift_pos)) cur_mode = MODE_SHIFT;
        else if (pos == int'(alpha_pos)) cur_mode = MODE_ALPHA;
        else cur_mode = MODE_NORMAL;
        presses++;
      end else if (rec != REC_RELEASED && !bits[s]) begin
        // release reports the mode recorded at press time
        ev_mode = mode_t'(rec - 2'd1);
        key_state[pos] = REC_RELEASED;
        releases++;
      end else begin
        continue;
      end
      ev.is_press = bits[s];
      ev.drive    = drv;
      ev.sense    = SENSE_IDX_W'(s);
      ev.shift    = (ev_mode == MODE_SHIFT);
      ev.alpha    = (ev_mode == MODE_ALPHA);
      ev.last     = 1'b0;
      if (ev.shift) shift_events++;
      if (ev.alpha) alpha_events++;
      if (have_held) add_expected(held);
      held = ev;
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      add_expected(held);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Mismatch reporting and output checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("tb: mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [3:0] got_v,
                             input logic [3:0] want_v, input int idx);
    if (got_v !== want_v)
      report_mismatch($sformatf("event %0d field %s got %0h expected %0h",
                                idx, name, got_v, want_v));
  endtask

  always @(posedge clk) begin
    key_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("event with none expected (drive %0d sense %0d)",
                                  key_drive, key_sense));
      end else begin
        want = pending_events.pop_front();
        check_field("is_press", 4'(is_press), 4'(want.is_press), events_checked);
        check_field("key_drive", 4'(key_drive), 4'(want.drive), events_checked);
        check_field("key_sense", key_sense, want.sense, events_checked);
        check_field("shift_flag", 4'(shift_flag), 4'(want.shift), events_checked);
        check_field("alpha_flag", 4'(alpha_flag), 4'(want.alpha), events_checked);
        check_field("last", 4'(last), 4'(want.last), events_checked);
        events_checked++;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      stall_left = HOLD_CYCLES - 1;
      hold_req = 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 9) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transfer or register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: timeout after %0d quiet cycles, %0d events pending",
               quiet_cycles, pending_events.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Shared stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one scan sample and hold it until the input transfer happens
  task automatic send_scan(input logic [DRIVE_W-1:0] drv,
                           input logic [SENSE_BITS_W-1:0] bits);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    drive_line <= drv;
    sense_bits <= bits;
    do @(posedge clk); while (!in_ready);
    scans_sent++;
    track_scan(drv, bits);
  endtask

  // Stop sending, wait for every queued event, then let any silent
  // samples leave the sequencer.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_SHIFT_KEY) shift_pos = val;
    else alpha_pos = val;
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly realistic scans: the current row with a few keys toggled, with
  // a bias toward the modifier keys; some noise rows and off-matrix lines.
  task automatic pick_scan(output logic [DRIVE_W-1:0] drv,
                           output logic [SENSE_BITS_W-1:0] bits);
    int r;
    int flips;
    int s;
    int mod_pos;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      drv  = DRIVE_W'($urandom_range(DRIVE_LINES, 7));
      bits = SENSE_BITS_W'($urandom_range(0, 511));
      return;
    end
    if (r < 26) begin
      mod_pos = (r < 16) ? int'(shift_pos) : int'(alpha_pos);
      if (mod_pos >= NUM_KEYS) mod_pos = $urandom_range(0, NUM_KEYS - 1);
      drv = DRIVE_W'(mod_pos / SENSE_LINES);
    end else begin
      mod_pos = -1;
      drv = DRIVE_W'($urandom_range(0, DRIVE_LINES - 1));
    end
    for (s = 0; s < SENSE_LINES; s++)
      bits[s] = (key_state[int'(drv) * SENSE_LINES + s] != REC_RELEASED);
    if (mod_pos >= 0) begin
      bits[mod_pos % SENSE_LINES] = ~bits[mod_pos % SENSE_LINES];
    end else if (r < 36) begin
      bits = SENSE_BITS_W'($urandom_range(0, 511));
    end else begin
      flips = $urandom_range(0, 3);
      repeat (flips) begin
        s = $urandom_range(0, SENSE_LINES - 1);
        bits[s] = ~bits[s];
      end
    end
  endtask

  task automatic run_random_scans(input int count);
    logic [DRIVE_W-1:0]      drv;
    logic [SENSE_BITS_W-1:0] bits;
    repeat (count) begin
      pick_scan(drv, bits);
      send_scan(drv, bits);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Single keys, modifiers, full rows, mixed press/release, off-matrix
  // drive lines and samples with no change, at the reset key positions.
  task automatic test_directed_scans();
    logic [DRIVE_W-1:0]      drvs [21];
    logic [SENSE_BITS_W-1:0] rows [21];
    drvs = '{3'd0, 3'd2, 3'd2, 3'd0, 3'd1, 3'd5, 3'd5, 3'd5, 3'd1, 3'd3, 3'd3,
             3'd3, 3'd3, 3'd6, 3'd7, 3'd4, 3'd4, 3'd4, 3'd0, 3'd0, 3'd1};
    rows = '{9'h001, 9'h008, 9'h000, 9'h000, 9'h001, 9'h100, 9'h100, 9'h000,
             9'h000, 9'h1FF, 9'h1FF, 9'h0AA, 9'h000, 9'h1FF, 9'h1FF, 9'h155,
             9'h0AA, 9'h000, 9'h003, 9'h000, 9'h1FF};
    for (int i = 0; i < 21; i++) send_scan(drvs[i], rows[i]);
    send_scan(3'd1, 9'h000);
  endtask

  // Both keys on one position, positions beyond the matrix, and the
  // corner positions of the matrix.
  task automatic test_key_registers();
    wait_idle();
    write_key_reg(CFG_SHIFT_KEY, 6'd53);
    write_key_reg(CFG_ALPHA_KEY, 6'd53);
    send_scan(3'd5, 9'h100);
    send_scan(3'd5, 9'h101);
    send_scan(3'd5, 9'h000);
    wait_idle();
    write_key_reg(CFG_SHIFT_KEY, 6'd63);
    write_key_reg(CFG_ALPHA_KEY, 6'd0);
    send_scan(3'd0, 9'h001);
    send_scan(3'd0, 9'h003);
    send_scan(3'd0, 9'h000);
    wait_idle();
    write_key_reg(CFG_SHIFT_KEY, 6'd9);
    write_key_reg(CFG_ALPHA_KEY, 6'd63);
    send_scan(3'd1, 9'h001);
    send_scan(3'd2, 9'h1FF);
    send_scan(3'd1, 9'h000);
    send_scan(3'd2, 9'h000);
  endtask

  // Random scans over several key register settings
  task automatic test_random_scans();
    wait_idle();
    write_key_reg(CFG_SHIFT_KEY, CFG_DATA_W'($urandom_range(0, NUM_KEYS - 1)));
    write_key_reg(CFG_ALPHA_KEY, CFG_DATA_W'($urandom_range(0, NUM_KEYS - 1)));
    run_random_scans(110);
    wait_idle();
    write_key_reg(CFG_SHIFT_KEY, CFG_DATA_W'($urandom_range(0, NUM_KEYS - 1)));
    write_key_reg(CFG_ALPHA_KEY, shift_pos);
    run_random_scans(90);
    wait_idle();
    write_key_reg(CFG_SHIFT_KEY, CFG_DATA_W'($urandom_range(0, 63)));
    write_key_reg(CFG_ALPHA_KEY, CFG_DATA_W'($urandom_range(0, 63)));
    run_random_scans(90);
  endtask

  // Long receiver hold-off while full rows keep arriving, so the input
  // queue fills and in_ready drops; then drain completely.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_scan(DRIVE_W'(i % DRIVE_LINES), (i < DRIVE_LINES) ? 9'h1FF : 9'h000);
    wait_idle();
  endtask

  // Closing stretch with both sides always ready
  task automatic test_final_stream();
    write_key_reg(CFG_SHIFT_KEY, SHIFT_KEY_RESET);
    write_key_reg(CFG_ALPHA_KEY, ALPHA_KEY_RESET);
    idle_en = 1'b0;
    run_random_scans(80);
  endtask

  initial begin
    clear_key_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_scans();
    test_key_registers();
    test_random_scans();
    test_backpressure();
    test_final_stream();
    wait_idle();
    $display("tb: %0d scans sent (%0d off-matrix), %0d events checked",
             scans_sent, scans_ignored, events_checked);
    $display("tb: %0d presses, %0d releases, %0d shift / %0d alpha events, %0d reg writes",
             presses, releases, shift_events, alpha_events, cfg_writes);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
